### rtl/lmc_pkg.sv
// lmc_pkg: types and constants shared by the light mode controller files
// depends on nothing; compile first
`timescale 1ns / 1ps

package lmc_pkg;

	// operating modes, cycled by a long center press
	typedef enum logic [1:0] {
		MODE_REST,
		MODE_DIRECT,
		MODE_TRACK,
		MODE_PROGRAM
	} mode_t;

	// program mode cursor positions
	typedef enum logic [1:0] {
		CUR_HOUR,
		CUR_MINUTE,
		CUR_SECOND,
		CUR_TARGET
	} cursor_t;

	// configuration register indexes
	localparam logic REG_DEADBAND   = 1'b0;
	localparam logic REG_ALARM_BAND = 1'b1;

	// button bit positions
	localparam int BTN_CENTER = 0;
	localparam int BTN_LONG   = 1;
	localparam int BTN_LEFT   = 2;
	localparam int BTN_RIGHT  = 3;
	localparam int BTN_UP     = 4;
	localparam int BTN_DOWN   = 5;

	// reset values
	localparam logic [15:0] DEADBAND_RESET   = 16'd160;
	localparam logic [15:0] ALARM_BAND_RESET = 16'd4000;
	localparam logic [11:0] TARGET_RESET     = 12'd1500;
	localparam logic [6:0]  DUTY_RESET       = 7'd50;

	// ranges and steps
	localparam logic [11:0] TARGET_MIN  = 12'd100;
	localparam logic [11:0] TARGET_MAX  = 12'd4000;
	localparam logic [11:0] TARGET_STEP = 12'd100;
	localparam logic [11:0] TARGET_SPAN = 12'd3900;
	localparam logic [6:0]  DUTY_MIN    = 7'd5;
	localparam logic [6:0]  DUTY_MAX    = 7'd95;
	localparam logic [6:0]  DUTY_SPAN   = 7'd90;
	localparam logic [11:0] POT_FULL    = 12'd4095;
	localparam logic [6:0]  ROUND_MUL   = 7'd78;
	localparam logic [5:0]  HOURS       = 6'd24;
	localparam logic [6:0]  MINUTES     = 7'd60;

	// breathing triangle: level = 65535*u/2500, u = 250+e rising, 4250-e falling
	localparam logic [11:0] BREATH_HALF = 12'd2000;
	localparam logic [11:0] BREATH_RISE = 12'd250;
	localparam logic [12:0] BREATH_FALL = 13'd4250;
	localparam logic [6:0]  BREATH_DIV  = 7'd125;
	localparam logic [16:0] FOLD_MUL    = 17'd9;

	// reciprocals: ceil(2^24/125) and ceil(2^36/625)
	localparam logic [17:0] RECIP_125 = 18'd134218;
	localparam logic [26:0] RECIP_625 = 27'd109951163;

	// one input transaction
	typedef struct packed {
		logic [31:0] now_ms;
		logic [5:0]  buttons;
		logic [20:0] lux;
		logic [11:0] pot_target;
		logic [11:0] pot_duty;
		logic [4:0]  clock_hour;
		logic [5:0]  clock_minute;
		logic [5:0]  clock_second;
	} in_t;

	// one result transaction
	typedef struct packed {
		logic [1:0]  mode;
		logic [6:0]  duty;
		logic [11:0] target_lux;
		logic        red_on;
		logic        blue_on;
		logic [15:0] green_level;
		logic        time_write;
		logic [4:0]  write_hour;
		logic [5:0]  write_minute;
		logic [5:0]  write_second;
		logic [1:0]  cursor;
		logic [11:0] edit_target;
	} out_t;

endpackage

### rtl/lmc_in_if.sv
// lmc_in_if: valid/ready channel carrying one tick transaction
// depends on lmc_pkg for the payload type
`timescale 1ns / 1ps

interface lmc_in_if;
	logic          valid;
	logic          ready;
	lmc_pkg::in_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/lmc_out_if.sv
// lmc_out_if: valid/ready channel carrying one result transaction
// depends on lmc_pkg for the payload type
`timescale 1ns / 1ps

interface lmc_out_if;
	logic          valid;
	logic          ready;
	lmc_pkg::out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/light_mode_controller.sv
// light_mode_controller: per-tick mode manager for an illuminance-regulated lamp
// a tick transaction is registered through stages 1 to 7 and then the output register before its result is valid
// throughput: one transaction per cycle while result.ready does not stall; mode state updates in stage 2, the
// breathing level then runs through the reciprocal-multiply pipeline of stages 3 to 7 and the output register
// reset: arst_n clears all valid bits and the mode state at once; no clearing pass
// depends on lmc_pkg, lmc_in_if, lmc_out_if
`timescale 1ns / 1ps

module light_mode_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	lmc_in_if.sink      tick,
	lmc_out_if.source   result
);
	import lmc_pkg::*;

	localparam int NSTAGE = 8;

	// floor(x/4095) for quotients below 4096
	function automatic logic [11:0] div_4095(input logic [23:0] x);
		logic [23:0] s;
		s = x + {12'd0, x[23:12]} + 24'd1;
		return s[23:12];
	endfunction

	function automatic logic [4:0] hour_inc(input logic [4:0] h);
		logic [5:0] s;
		s = {1'b0, h} + 6'd1;
		if (s >= HOURS) s = s - HOURS;
		return s[4:0];
	endfunction

	function automatic logic [4:0] hour_dec(input logic [4:0] h);
		logic [5:0] s;
		s = HOURS - 6'd1;
		return (h == 5'd0) ? s[4:0] : h - 5'd1;
	endfunction

	function automatic logic [5:0] min_inc(input logic [5:0] m);
		logic [6:0] s;
		s = {1'b0, m} + 7'd1;
		if (s >= MINUTES) s = s - MINUTES;
		return s[5:0];
	endfunction

	function automatic logic [5:0] min_dec(input logic [5:0] m);
		logic [6:0] s;
		s = MINUTES - 7'd1;
		return (m == 6'd0) ? s[5:0] : m - 6'd1;
	endfunction

	// |lux - 16*t| > band, without a signed subtract
	function automatic logic over_band(input logic [20:0] lx, input logic [11:0] t,
			input logic [15:0] band);
		logic [21:0] t16;
		t16 = {6'd0, t, 4'd0};
		return ({1'b0, lx} > t16 + {6'd0, band}) || (t16 > {1'b0, lx} + {6'd0, band});
	endfunction

	// configuration registers
	logic [15:0] deadband_q;
	logic [15:0] alarm_band_q;

	// mode state
	mode_t       mode_q;
	cursor_t     cursor_q;
	logic [11:0] target_q;
	logic [11:0] tround_q;
	logic [6:0]  duty_q;
	logic [31:0] origin_q;
	logic [4:0]  ehour_q;
	logic [5:0]  emin_q;
	logic [5:0]  esec_q;
	logic [11:0] etarget_q;

	// pipeline control
	logic [NSTAGE-1:0] vld_q;
	logic [NSTAGE-1:0] adv;
	logic              fire;

	// pipeline payload
	in_t         in_s1;
	in_t         in_s2;
	logic [11:0] map_target_s2;
	logic [6:0]  map_duty_s2;
	logic [5:0]  map_q_s2;
	out_t        res_s3, res_s4, res_s5, res_s6, res_s7;
	logic        rest_s3, rest_s4, rest_s5, rest_s6, rest_s7;
	logic [31:0] diff_s3;
	logic [16:0] fold_s4, fold_s5;
	logic [4:0]  low5_s4, low5_s5;
	logic [9:0]  quo_s5;
	logic [11:0] u_s6;
	logic [25:0] x2_s7;
	out_t        out_q;

	// apb port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q   <= DEADBAND_RESET;
			alarm_band_q <= ALARM_BAND_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_DEADBAND:   deadband_q   <= pwdata[15:0];
				REG_ALARM_BAND: alarm_band_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEADBAND:   prdata = {16'd0, deadband_q};
			REG_ALARM_BAND: prdata = {16'd0, alarm_band_q};
			default:        prdata = '0;
		endcase
	end

	// elastic pipeline: a stage moves when empty or when the next one moves
	always_comb begin
		adv[NSTAGE-1] = !vld_q[NSTAGE-1] || result.ready;
		for (int i = NSTAGE - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign tick.ready   = adv[0];
	assign result.valid = vld_q[NSTAGE-1];
	assign result.data  = out_q;
	assign fire         = vld_q[1] && adv[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= tick.valid;
			for (int i = 1; i < NSTAGE; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (adv[0]) in_s1 <= tick.data;
	end

	// potentiometer mapping by 4095, target rounding by 2*4095, all through div_4095
	logic [23:0] tprod, dprod, rprod;
	logic [11:0] tq, dq, rq;

	always_comb begin
		tprod = {12'd0, in_s1.pot_target} * {12'd0, TARGET_SPAN};
		dprod = {12'd0, in_s1.pot_duty} * {17'd0, DUTY_SPAN};
		rprod = {12'd0, in_s1.pot_target} * {17'd0, ROUND_MUL} + {12'd0, POT_FULL};
		tq    = div_4095(tprod);
		dq    = div_4095(dprod);
		rq    = div_4095({1'b0, rprod[23:1]});
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			in_s2         <= in_s1;
			map_target_s2 <= TARGET_MIN + tq;
			map_duty_s2   <= DUTY_MIN + dq[6:0];
			map_q_s2      <= rq[5:0];
		end
	end

	// mode state next values
	mode_t       mode_n;
	cursor_t     cursor_n;
	logic [11:0] target_n, tround_n, etarget_n;
	logic [6:0]  duty_n;
	logic [31:0] origin_n, diff_n;
	logic [4:0]  ehour_n;
	logic [5:0]  emin_n, esec_n;
	logic        red_n, blue_n, wr_n, rest_n;
	logic        center, longp;
	logic [21:0] t16, lux_db, t16_db;
	logic [12:0] et_up;
	logic [11:0] map_round;

	always_comb begin
		center    = in_s2.buttons[BTN_CENTER];
		longp     = in_s2.buttons[BTN_LONG];
		mode_n    = mode_q;
		cursor_n  = cursor_q;
		target_n  = target_q;
		tround_n  = tround_q;
		duty_n    = duty_q;
		origin_n  = origin_q;
		ehour_n   = ehour_q;
		emin_n    = emin_q;
		esec_n    = esec_q;
		etarget_n = etarget_q;
		red_n     = 1'b0;
		blue_n    = 1'b0;
		wr_n      = 1'b0;
		rest_n    = 1'b0;
		diff_n    = '0;
		t16       = {6'd0, target_q, 4'd0};
		lux_db    = {1'b0, in_s2.lux} + {6'd0, deadband_q};
		t16_db    = t16 + {6'd0, deadband_q};
		map_round = ({6'd0, map_q_s2} + 12'd1) * TARGET_STEP;
		et_up     = '0;

		// long press steps the mode; entering program latches the edit fields
		if (center && longp) begin
			if (mode_q == MODE_TRACK) begin
				ehour_n   = in_s2.clock_hour;
				emin_n    = in_s2.clock_minute;
				esec_n    = in_s2.clock_second;
				etarget_n = tround_q;
				cursor_n  = CUR_TARGET;
			end
			mode_n = mode_t'(mode_q + 2'd1);
		end

		unique case (mode_n)
			MODE_REST: begin
				rest_n = 1'b1;
				if (origin_q == 32'd0) origin_n = in_s2.now_ms;
				diff_n = in_s2.now_ms - origin_n;
			end
			MODE_DIRECT: begin
				target_n = map_target_s2;
				tround_n = map_round;
				duty_n   = map_duty_s2;
				red_n    = over_band(in_s2.lux, map_target_s2, alarm_band_q);
			end
			MODE_TRACK: begin
				if (t16 > lux_db) begin
					if (duty_q < DUTY_MAX) duty_n = duty_q + 7'd1;
				end else if ({1'b0, in_s2.lux} > t16_db) begin
					if (duty_q > DUTY_MIN) duty_n = duty_q - 7'd1;
				end
				blue_n = over_band(in_s2.lux, target_q, alarm_band_q);
			end
			MODE_PROGRAM: begin
				// cursor moves, left first
				if (in_s2.buttons[BTN_LEFT] && cursor_n != CUR_HOUR)
					cursor_n = cursor_t'(cursor_n - 2'd1);
				if (in_s2.buttons[BTN_RIGHT] && cursor_n != CUR_TARGET)
					cursor_n = cursor_t'(cursor_n + 2'd1);
				// field edits, up first
				unique case (cursor_n)
					CUR_HOUR: begin
						if (in_s2.buttons[BTN_UP]) ehour_n = hour_inc(ehour_n);
						if (in_s2.buttons[BTN_DOWN]) ehour_n = hour_dec(ehour_n);
					end
					CUR_MINUTE: begin
						if (in_s2.buttons[BTN_UP]) emin_n = min_inc(emin_n);
						if (in_s2.buttons[BTN_DOWN]) emin_n = min_dec(emin_n);
					end
					CUR_SECOND: begin
						if (in_s2.buttons[BTN_UP]) esec_n = min_inc(esec_n);
						if (in_s2.buttons[BTN_DOWN]) esec_n = min_dec(esec_n);
					end
					CUR_TARGET: begin
						et_up = {1'b0, etarget_n} + {1'b0, TARGET_STEP};
						if (in_s2.buttons[BTN_UP])
							etarget_n = (et_up < {1'b0, TARGET_MAX}) ? et_up[11:0] : TARGET_MAX;
						if (in_s2.buttons[BTN_DOWN])
							etarget_n = (etarget_n > TARGET_MIN + TARGET_STEP) ?
								etarget_n - TARGET_STEP : TARGET_MIN;
					end
					default: ;
				endcase
				// short center press applies the edits
				if (center && !longp) begin
					target_n = etarget_n;
					tround_n = etarget_n;
					wr_n     = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_REST;
			cursor_q  <= CUR_TARGET;
			target_q  <= TARGET_RESET;
			tround_q  <= TARGET_RESET;
			duty_q    <= DUTY_RESET;
			origin_q  <= '0;
			ehour_q   <= '0;
			emin_q    <= '0;
			esec_q    <= '0;
			etarget_q <= TARGET_RESET;
		end else if (fire) begin
			mode_q    <= mode_n;
			cursor_q  <= cursor_n;
			target_q  <= target_n;
			tround_q  <= tround_n;
			duty_q    <= duty_n;
			origin_q  <= origin_n;
			ehour_q   <= ehour_n;
			emin_q    <= emin_n;
			esec_q    <= esec_n;
			etarget_q <= etarget_n;
		end
	end

	// stage 3: result fields except the green level
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			res_s3.mode         <= mode_n;
			res_s3.duty         <= duty_n;
			res_s3.target_lux   <= target_n;
			res_s3.red_on       <= red_n;
			res_s3.blue_on      <= blue_n;
			res_s3.green_level  <= '0;
			res_s3.time_write   <= wr_n;
			res_s3.write_hour   <= wr_n ? ehour_n : 5'd0;
			res_s3.write_minute <= wr_n ? emin_n : 6'd0;
			res_s3.write_second <= wr_n ? esec_n : 6'd0;
			res_s3.cursor       <= cursor_n;
			res_s3.edit_target  <= etarget_n;
			rest_s3             <= rest_n;
			diff_s3             <= diff_n;
		end
	end

	// stage 4: fold (diff >> 5) modulo 125 using 2^14 = 9 mod 125
	logic [26:0] dp;
	logic [16:0] fold;

	always_comb begin
		dp   = diff_s3[31:5];
		fold = {4'd0, dp[26:14]} * FOLD_MUL + {3'd0, dp[13:0]};
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			res_s4  <= res_s3;
			rest_s4 <= rest_s3;
			fold_s4 <= fold;
			low5_s4 <= diff_s3[4:0];
		end
	end

	// stage 5: quotient by 125 through the reciprocal
	logic [34:0] qprod;

	assign qprod = {18'd0, fold_s4} * {17'd0, RECIP_125};

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			res_s5  <= res_s4;
			rest_s5 <= rest_s4;
			fold_s5 <= fold_s4;
			quo_s5  <= qprod[33:24];
			low5_s5 <= low5_s4;
		end
	end

	// stage 6: phase within the 4 s period and triangle slope term
	logic [16:0] rem;
	logic [11:0] phase;
	logic [12:0] fall;
	logic [11:0] u_n;

	always_comb begin
		rem   = fold_s5 - {7'd0, quo_s5} * {10'd0, BREATH_DIV};
		phase = {rem[6:0], low5_s5};
		fall  = BREATH_FALL - {1'b0, phase};
		u_n   = (phase < BREATH_HALF) ? phase + BREATH_RISE : fall[11:0];
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			res_s6  <= res_s5;
			rest_s6 <= rest_s5;
			u_s6    <= u_n;
		end
	end

	// stage 7: 65535*u, pre-divided by 4
	logic [27:0] uprod;

	assign uprod = {u_s6, 16'd0} - {16'd0, u_s6};

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			res_s7  <= res_s6;
			rest_s7 <= rest_s6;
			x2_s7   <= uprod[27:2];
		end
	end

	// output register: divide by 625 through the reciprocal
	logic [52:0] gprod;
	out_t        out_n;

	assign gprod = {27'd0, x2_s7} * {26'd0, RECIP_625};

	always_comb begin
		out_n             = res_s7;
		out_n.green_level = rest_s7 ? gprod[51:36] : 16'd0;
	end

	always_ff @(posedge clk) begin
		if (adv[7]) out_q <= out_n;
	end

endmodule
